### design/u16u8_pkg.sv
// shared types and constants of the utf-16be to utf-8 converter
// no dependencies; used by every module of the block
package u16u8_pkg;

	// one raw input byte of the utf-16be string
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_t;

	// one utf-8 output byte
	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       byte_valid;
		logic       last_of_input;
		logic       end_of_string;
	} out_t;

	// kind of output group produced by one input byte
	localparam logic [2:0] KIND_MARK  = 3'd0;
	localparam logic [2:0] KIND_ONE   = 3'd1;
	localparam logic [2:0] KIND_TWO   = 3'd2;
	localparam logic [2:0] KIND_THREE = 3'd3;
	localparam logic [2:0] KIND_FOUR  = 3'd4;

	localparam int CP_W = 21;

	// surrogate and range limits
	localparam logic [15:0] HI_SUR_LO  = 16'hD800;
	localparam logic [15:0] HI_SUR_HI  = 16'hDBFF;
	localparam logic [15:0] LO_SUR_LO  = 16'hDC00;
	localparam logic [15:0] LO_SUR_HI  = 16'hDFFF;
	localparam logic [15:0] ONE_LIMIT  = 16'h0080;
	localparam logic [15:0] TWO_LIMIT  = 16'h0800;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	// one classified request passed from front to back
	typedef struct packed {
		logic [2:0]      kind;
		logic [CP_W-1:0] cp;
		logic            last;
	} job_t;

	localparam int QDEPTH = 2;

endpackage

### design/u16u8_front.sv
// front part: pairs bytes into utf-16 units, tracks surrogates and stop state,
// and turns accepted bytes into output jobs when bytes are produced or the string ends; uses u16u8_pkg
module u16u8_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  u16u8_pkg::in_t     item,
	output logic               job_push,
	output u16u8_pkg::job_t    job
);

	logic [7:0] held_byte_q;
	logic       byte_held_q;
	logic [9:0] pend_q;
	logic       high_pending_q;
	logic       stopped_q;

	logic [7:0] held_byte_d;
	logic       byte_held_d;
	logic [9:0] pend_d;
	logic       high_pending_d;
	logic       stopped_d;

	logic [15:0] unit;
	logic        is_last;
	logic        gen;
	logic [2:0]  kind;
	logic [u16u8_pkg::CP_W-1:0] cp;

	assign unit    = {held_byte_q, item.in_byte};
	assign is_last = item.last_byte;

	// next state and classification of the current byte
	always_comb begin
		held_byte_d    = held_byte_q;
		byte_held_d    = byte_held_q;
		pend_d         = pend_q;
		high_pending_d = high_pending_q;
		stopped_d      = stopped_q;
		gen            = 1'b0;
		kind           = u16u8_pkg::KIND_MARK;
		cp             = '0;
		if (!byte_held_q) begin
			held_byte_d = item.in_byte;
			byte_held_d = 1'b1;
			// held high surrogate closes the string: emit it alone
			if (is_last && high_pending_q && !stopped_q) begin
				gen  = 1'b1;
				kind = u16u8_pkg::KIND_THREE;
				cp   = {5'd0, 6'b110110, pend_q};
			end
		end else begin
			byte_held_d = 1'b0;
			if (!stopped_q) begin
				if (high_pending_q && unit >= u16u8_pkg::LO_SUR_LO
						&& unit <= u16u8_pkg::LO_SUR_HI) begin
					high_pending_d = 1'b0;
					gen  = 1'b1;
					kind = u16u8_pkg::KIND_FOUR;
					cp   = u16u8_pkg::SUPP_BASE + {1'b0, pend_q, unit[9:0]};
				end else begin
					high_pending_d = 1'b0;
					if (unit == 16'd0) begin
						stopped_d = 1'b1;
					end else if (unit >= u16u8_pkg::HI_SUR_LO
							&& unit <= u16u8_pkg::HI_SUR_HI && !is_last) begin
						pend_d         = unit[9:0];
						high_pending_d = 1'b1;
					end else begin
						gen = 1'b1;
						cp  = {5'd0, unit};
						if (unit < u16u8_pkg::ONE_LIMIT) begin
							kind = u16u8_pkg::KIND_ONE;
						end else if (unit < u16u8_pkg::TWO_LIMIT) begin
							kind = u16u8_pkg::KIND_TWO;
						end else begin
							kind = u16u8_pkg::KIND_THREE;
						end
					end
				end
			end
		end
		// string end clears all string state
		if (is_last) begin
			byte_held_d    = 1'b0;
			high_pending_d = 1'b0;
			stopped_d      = 1'b0;
		end
	end

	// a job goes out when bytes are produced or the string ends
	assign job_push = take && (gen || is_last);
	assign job.kind = gen ? kind : u16u8_pkg::KIND_MARK;
	assign job.cp   = cp;
	assign job.last = is_last;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_held_q    <= 1'b0;
			high_pending_q <= 1'b0;
			stopped_q      <= 1'b0;
		end else if (take) begin
			byte_held_q    <= byte_held_d;
			high_pending_q <= high_pending_d;
			stopped_q      <= stopped_d;
		end
	end

	// payload state
	always_ff @(posedge clk) begin
		if (take) begin
			held_byte_q <= held_byte_d;
			pend_q      <= pend_d;
		end
	end

endmodule

### design/u16u8_queue.sv
// short job queue between front and back parts
// uses u16u8_pkg for the job type and depth
module u16u8_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  u16u8_pkg::job_t wdata,
	output logic            full,
	input  logic            rd,
	output logic            nempty,
	output u16u8_pkg::job_t rdata
);

	localparam int PW = $clog2(u16u8_pkg::QDEPTH);
	localparam int CW = $clog2(u16u8_pkg::QDEPTH + 1);

	u16u8_pkg::job_t slot_q [u16u8_pkg::QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == CW'(u16u8_pkg::QDEPTH));
	assign nempty = (cnt_q != '0);
	assign rdata  = slot_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(u16u8_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(u16u8_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

endmodule

### design/u16u8_back.sv
// back part: expands one job into its utf-8 bytes, one byte per cycle while pop is high
// uses u16u8_pkg for job and result types
module u16u8_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_avail,
	input  u16u8_pkg::job_t  job,
	output logic             job_pop,
	output logic             empty,
	input  logic             pop,
	output u16u8_pkg::out_t  result
);

	u16u8_pkg::job_t cur_q;
	logic            busy_q;
	logic [1:0]      idx_q;
	logic [1:0]      last_idx;
	logic            at_last;
	logic            done;
	logic [7:0]      byte_out;

	// index of the final byte of the current job
	always_comb begin
		case (cur_q.kind)
			u16u8_pkg::KIND_TWO:   last_idx = 2'd1;
			u16u8_pkg::KIND_THREE: last_idx = 2'd2;
			u16u8_pkg::KIND_FOUR:  last_idx = 2'd3;
			default:               last_idx = 2'd0;
		endcase
	end

	// byte select by kind and position
	always_comb begin
		byte_out = 8'h00;
		case (cur_q.kind)
			u16u8_pkg::KIND_ONE: byte_out = {1'b0, cur_q.cp[6:0]};
			u16u8_pkg::KIND_TWO: begin
				byte_out = (idx_q == 2'd0) ? {3'b110, cur_q.cp[10:6]}
					: {2'b10, cur_q.cp[5:0]};
			end
			u16u8_pkg::KIND_THREE: begin
				case (idx_q)
					2'd0:    byte_out = {4'b1110, cur_q.cp[15:12]};
					2'd1:    byte_out = {2'b10, cur_q.cp[11:6]};
					default: byte_out = {2'b10, cur_q.cp[5:0]};
				endcase
			end
			u16u8_pkg::KIND_FOUR: begin
				case (idx_q)
					2'd0:    byte_out = {5'b11110, cur_q.cp[20:18]};
					2'd1:    byte_out = {2'b10, cur_q.cp[17:12]};
					2'd2:    byte_out = {2'b10, cur_q.cp[11:6]};
					default: byte_out = {2'b10, cur_q.cp[5:0]};
				endcase
			end
			default: byte_out = 8'h00;
		endcase
	end

	assign at_last = (idx_q == last_idx);
	assign empty   = !busy_q;
	assign done    = busy_q && pop && at_last;
	assign job_pop = job_avail && (!busy_q || done);

	assign result.utf8_byte     = byte_out;
	assign result.byte_valid    = (cur_q.kind != u16u8_pkg::KIND_MARK);
	assign result.last_of_input = at_last;
	assign result.end_of_string = at_last && cur_q.last;

	// current job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (busy_q && pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// current job payload
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
		end
	end

endmodule

### design/utf16be_to_utf8_unit.sv
// top level of the utf-16be to utf-8 converter
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back
//
// channel   direction  handshake           payload
// item      in         push / full         u16u8_pkg::in_t  (in_byte, last_byte)
// result    out        empty / pop         u16u8_pkg::out_t (utf8_byte, flags)
//
// one input byte is taken per cycle while the job queue has room
// each input byte yields 0 to 4 result bytes; the back part sends one per cycle while pop is high
// sustained rate is set by the output side
// first result is on the ports once its job has passed the queue and the back part's job register
// reset clears all string state; stalls on either side are absorbed by the queue
module utf16be_to_utf8_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  u16u8_pkg::in_t  item,
	output logic            empty,
	input  logic            pop,
	output u16u8_pkg::out_t result
);

	logic            take;
	logic            job_push;
	u16u8_pkg::job_t job_in;
	logic            q_nempty;
	logic            q_pop;
	u16u8_pkg::job_t job_out;

	assign take = push && !full;

	// front: pairing and classification
	u16u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.job_push (job_push),
		.job      (job_in)
	);

	// queue between the two parts
	u16u8_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (full),
		.rd     (q_pop),
		.nempty (q_nempty),
		.rdata  (job_out)
	);

	// back: byte serialization
	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (q_nempty),
		.job       (job_out),
		.job_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

### design/u16u8_checker.sv
// port-level checks for utf16be_to_utf8_unit, attached by bind
// uses u16u8_pkg for the port types
module u16u8_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            empty,
	input logic            pop,
	input u16u8_pkg::out_t result
);

	// waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	// bare end marker always closes the string
	a_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.byte_valid |-> result.end_of_string && result.last_of_input)
		else $error("bare marker without end flags");

	// end of string only on the final byte of a request
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.end_of_string |-> result.last_of_input)
		else $error("end of string before last byte of request");

	// rest of a multi-byte sequence follows at once
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !result.last_of_input |=> !empty)
		else $error("multi-byte sequence broken");

	// no byte of f8 or above in the utf-8 output
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.byte_valid |-> result.utf8_byte[7:3] != 5'b11111)
		else $error("illegal utf-8 byte");

endmodule

bind utf16be_to_utf8_unit u16u8_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
